FILE: hdl/alcd_pkg.sv
package alcd_pkg;

    localparam int ENTRIES   = 8;
    localparam int AGE_BITS  = 16;
    localparam int KEY_W     = 64;
    localparam int SIZE_W    = 24;
    localparam int SLOT_W    = 3;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int ENTRY_W   = AGE_BITS + KEY_W;

    localparam logic [AGE_BITS-1:0] AGE_MAX     = {AGE_BITS{1'b1}};
    localparam logic [SIZE_W-1:0]   LIMIT_RESET = SIZE_W'(102400);
    localparam logic [IDX_W-1:0]    LAST_IDX    = IDX_W'(ENTRIES - 1);

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OP_HIT,
        OP_MISS,
        OP_ROLLBACK
    } upd_op_t;

    // Running outcome of the scan pass, including the beat presented this cycle.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] victim;
    } scan_res_t;

    function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
        return (a == AGE_MAX) ? a : a + AGE_BITS'(1);
    endfunction

    function automatic logic [AGE_BITS-1:0] age_dec(input logic [AGE_BITS-1:0] a);
        return (a == '0) ? a : a - AGE_BITS'(1);
    endfunction

endpackage

FILE: hdl/alcd_ram.sv
module alcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/alcd_scan.sv
module alcd_scan (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic                            beat,
    input  logic [alcd_pkg::IDX_W-1:0]      beat_idx,
    input  logic                            beat_valid,
    input  logic [alcd_pkg::AGE_BITS-1:0]   beat_age,
    input  logic [alcd_pkg::KEY_W-1:0]      beat_key,
    input  logic [alcd_pkg::KEY_W-1:0]      lookup_key,
    output alcd_pkg::scan_res_t             res
);

    import alcd_pkg::*;

    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                inv_reg, inv_next;
    logic [IDX_W-1:0]    inv_idx_reg, inv_idx_next;
    logic [AGE_BITS-1:0] top_reg, top_next;
    logic [IDX_W-1:0]    best_reg, best_next;

    // First valid match, first invalid slot, and first strictly oldest slot.
    always_comb begin
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        inv_next     = inv_reg;
        inv_idx_next = inv_idx_reg;
        top_next     = top_reg;
        best_next    = best_reg;
        if (start) begin
            hit_next     = 1'b0;
            hit_idx_next = '0;
            inv_next     = 1'b0;
            inv_idx_next = '0;
            top_next     = '0;
            best_next    = '0;
        end else if (beat) begin
            if (!hit_reg && beat_valid && beat_key == lookup_key) begin
                hit_next     = 1'b1;
                hit_idx_next = beat_idx;
            end
            if (!inv_reg && !beat_valid) begin
                inv_next     = 1'b1;
                inv_idx_next = beat_idx;
            end
            if (beat_age > top_reg) begin
                top_next  = beat_age;
                best_next = beat_idx;
            end
        end
    end

    always_comb begin
        res.hit     = hit_next;
        res.hit_idx = hit_idx_next;
        res.victim  = inv_next ? inv_idx_next : best_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
            inv_reg     <= 1'b0;
            inv_idx_reg <= '0;
            top_reg     <= '0;
            best_reg    <= '0;
        end else begin
            hit_reg     <= hit_next;
            hit_idx_reg <= hit_idx_next;
            inv_reg     <= inv_next;
            inv_idx_reg <= inv_idx_next;
            top_reg     <= top_next;
            best_reg    <= best_next;
        end
    end

endmodule

FILE: hdl/aging_lru_cache_directory.sv
// Fully associative cache directory of eight slots with per-slot age counters.
// Each request is either a lookup of a 64-bit key (kind 0) or the completion of
// a pending fill carrying its fetched size (kind 1), and produces exactly one
// response. A lookup that hits clears the matching slot's age and ages every
// other slot; a miss takes the first invalid slot, otherwise the first slot with
// the strictly largest age, saves its old contents as a backup, ages the others
// and fills the slot with the new key as pending. A completion that arrives while
// a fill is pending and whose size is at or above object_size_limit restores the
// backup and makes the other slots one step younger. Ages and keys live in a
// single-port-read, single-port-write RAM with a registered read port; valid bits
// are flip-flops. A lookup runs a scan pass and then a read-modify-write pass
// over that RAM, registers its response and returns to idle; a completion that
// rolls back runs only the read-modify-write pass, and any other completion goes
// straight to its response. One request is processed at a time; the next request
// is taken once the previous response is registered.
// object_size_limit resets to 102400 and may be written through cfg_wr_en and
// cfg_wr_data while the block is idle.
module aging_lru_cache_directory (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [alcd_pkg::SIZE_W-1:0]   cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [alcd_pkg::KEY_W-1:0]    s_lookup_key,
    input  logic [alcd_pkg::SIZE_W-1:0]   s_fill_size,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [alcd_pkg::SLOT_W-1:0]   m_slot,
    output logic                          m_rolled_back,
    output logic                          m_acted
);

    import alcd_pkg::*;

    ctrl_state_t state_reg, state_next;

    // Sweep control: address issued to the RAM and the beat returning from it.
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                issue_reg, issue_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]    ridx_reg, ridx_next;
    logic                phase_start;
    logic                last_beat;

    // Directory state outside the RAM.
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [ENTRIES-1:0]  init_reg, init_next;
    logic                bk_valid_reg, bk_valid_next;
    logic [AGE_BITS-1:0] bk_age_reg, bk_age_next;
    logic [KEY_W-1:0]    bk_key_reg, bk_key_next;
    logic [IDX_W-1:0]    pend_slot_reg, pend_slot_next;
    logic                fill_pend_reg, fill_pend_next;
    logic [SIZE_W-1:0]   limit_reg, limit_next;

    // Per-request working registers.
    upd_op_t             op_reg, op_next;
    logic [IDX_W-1:0]    target_reg, target_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                res_hit_reg, res_hit_next;
    logic                res_rb_reg, res_rb_next;
    logic                res_acted_reg, res_acted_next;

    // Response register.
    logic                m_valid_reg, m_valid_next;
    logic                m_hit_reg, m_hit_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic                m_rb_reg, m_rb_next;
    logic                m_acted_reg, m_acted_next;

    // RAM ports.
    logic                wr_en;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ENTRY_W-1:0]  rd_data;
    logic [AGE_BITS-1:0] rd_age;
    logic [KEY_W-1:0]    rd_key;

    logic                scan_start;
    logic                scan_beat;
    scan_res_t           scan_res;
    logic                accept;
    logic                over_limit;

    alcd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ridx_reg),
        .wr_data (wr_data),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    // A slot never written since reset reads as age zero.
    assign rd_age = init_reg[ridx_reg] ? rd_data[ENTRY_W-1:KEY_W] : '0;
    assign rd_key = rd_data[KEY_W-1:0];

    assign accept     = s_valid && s_ready;
    assign over_limit = s_fill_size >= limit_reg;
    assign last_beat  = rd_pend_reg && ridx_reg == LAST_IDX;
    assign scan_beat  = rd_pend_reg && state_reg == ST_SCAN;
    assign scan_start = accept && s_kind == KIND_LOOKUP;

    alcd_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .beat       (scan_beat),
        .beat_idx   (ridx_reg),
        .beat_valid (valid_reg[ridx_reg]),
        .beat_age   (rd_age),
        .beat_key   (rd_key),
        .lookup_key (key_reg),
        .res        (scan_res)
    );

    assign s_ready       = state_reg == ST_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_slot        = m_slot_reg;
    assign m_rolled_back = m_rb_reg;
    assign m_acted       = m_acted_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_LOOKUP) begin
                        state_next = ST_SCAN;
                    end else if (fill_pend_reg && over_limit) begin
                        state_next = ST_UPDATE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (last_beat) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (last_beat) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs for each state.
    always_comb begin
        phase_start    = 1'b0;
        wr_en          = 1'b0;
        wr_data        = rd_data;
        valid_next     = valid_reg;
        init_next      = init_reg;
        bk_valid_next  = bk_valid_reg;
        bk_age_next    = bk_age_reg;
        bk_key_next    = bk_key_reg;
        pend_slot_next = pend_slot_reg;
        fill_pend_next = fill_pend_reg;
        limit_next     = cfg_wr_en ? cfg_wr_data : limit_reg;
        op_next        = op_reg;
        target_next    = target_reg;
        key_next       = key_reg;
        res_hit_next   = res_hit_reg;
        res_rb_next    = res_rb_reg;
        res_acted_next = res_acted_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_hit_next     = m_hit_reg;
        m_slot_next    = m_slot_reg;
        m_rb_next      = m_rb_reg;
        m_acted_next   = m_acted_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_hit_next   = 1'b0;
                    res_rb_next    = 1'b0;
                    res_acted_next = 1'b1;
                    if (s_kind == KIND_LOOKUP) begin
                        key_next    = s_lookup_key;
                        phase_start = 1'b1;
                    end else if (fill_pend_reg) begin
                        target_next = pend_slot_reg;
                        if (over_limit) begin
                            op_next     = OP_ROLLBACK;
                            res_rb_next = 1'b1;
                            phase_start = 1'b1;
                        end else begin
                            fill_pend_next = 1'b0;
                        end
                    end else begin
                        // Completion with no fill outstanding changes nothing.
                        target_next    = '0;
                        res_acted_next = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (last_beat) begin
                    phase_start = 1'b1;
                    if (scan_res.hit) begin
                        op_next      = OP_HIT;
                        target_next  = scan_res.hit_idx;
                        res_hit_next = 1'b1;
                    end else begin
                        op_next     = OP_MISS;
                        target_next = scan_res.victim;
                    end
                end
            end
            ST_UPDATE: begin
                if (rd_pend_reg) begin
                    wr_en               = 1'b1;
                    init_next[ridx_reg] = 1'b1;
                    if (ridx_reg == target_reg) begin
                        case (op_reg)
                            OP_HIT: begin
                                wr_data = {AGE_BITS'(0), rd_key};
                            end
                            OP_MISS: begin
                                // Save the victim's old contents before refilling it.
                                bk_valid_next        = valid_reg[ridx_reg];
                                bk_age_next          = rd_age;
                                bk_key_next          = rd_key;
                                wr_data              = {AGE_BITS'(0), key_reg};
                                valid_next[ridx_reg] = 1'b1;
                                pend_slot_next       = ridx_reg;
                                fill_pend_next       = 1'b1;
                            end
                            OP_ROLLBACK: begin
                                wr_data              = {bk_age_reg, bk_key_reg};
                                valid_next[ridx_reg] = bk_valid_reg;
                            end
                            default: wr_data = rd_data;
                        endcase
                    end else if (op_reg == OP_ROLLBACK) begin
                        wr_data = {age_dec(rd_age), rd_key};
                    end else begin
                        wr_data = {age_inc(rd_age), rd_key};
                    end
                    if (last_beat && op_reg == OP_ROLLBACK) begin
                        fill_pend_next = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_slot_next  = SLOT_W'(target_reg);
                    m_rb_next    = res_rb_reg;
                    m_acted_next = res_acted_reg;
                end
            end
            default: begin
                phase_start = 1'b0;
            end
        endcase
    end

    // Address sequencer shared by the scan and update sweeps.
    always_comb begin
        cnt_next     = cnt_reg;
        issue_next   = issue_reg;
        rd_pend_next = issue_reg;
        ridx_next    = cnt_reg;
        if (phase_start) begin
            cnt_next   = '0;
            issue_next = 1'b1;
        end else if (issue_reg) begin
            if (cnt_reg == LAST_IDX) begin
                issue_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            ridx_reg      <= '0;
            valid_reg     <= '0;
            init_reg      <= '0;
            bk_valid_reg  <= 1'b0;
            bk_age_reg    <= '0;
            bk_key_reg    <= '0;
            pend_slot_reg <= '0;
            fill_pend_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            op_reg        <= OP_HIT;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            rd_pend_reg   <= rd_pend_next;
            ridx_reg      <= ridx_next;
            valid_reg     <= valid_next;
            init_reg      <= init_next;
            bk_valid_reg  <= bk_valid_next;
            bk_age_reg    <= bk_age_next;
            bk_key_reg    <= bk_key_next;
            pend_slot_reg <= pend_slot_next;
            fill_pend_reg <= fill_pend_next;
            limit_reg     <= limit_next;
            op_reg        <= op_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        target_reg    <= target_next;
        key_reg       <= key_next;
        res_hit_reg   <= res_hit_next;
        res_rb_reg    <= res_rb_next;
        res_acted_reg <= res_acted_next;
        m_hit_reg     <= m_hit_next;
        m_slot_reg    <= m_slot_next;
        m_rb_reg      <= m_rb_next;
        m_acted_reg   <= m_acted_next;
    end

endmodule

FILE: bench/tb_aging_lru_cache_directory.sv
`timescale 1ns / 1ps

// Testbench for the aging LRU cache directory.
module tb_aging_lru_cache_directory;
    import alcd_pkg::*;

    // Runaway guard. The slowest legal run has about 500 requests, and each one costs
    // at most one whole lookup in the block, the longest sender gap and the longest
    // receiver stall. Together with the drains this stays well under CYCLE_LIMIT.
    localparam int CYCLE_LIMIT   = 500000;
    // Waiting a little longer than a whole lookup leaves the controller back in idle
    // before the next register write.
    localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
    localparam int PHASE_ITEMS   = 72;
    localparam int PHASE_COUNT   = 6;
    localparam int POOL_KEYS     = 12;

    // One response, laid out field by field as the result channel carries it.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              rolled_back;
        logic              acted;
    } dir_resp_t;

    // Keeps a private copy of the directory, the backup and the size limit. It
    // turns every accepted request into the response that the block must give.
    class dir_scoreboard;
        logic                slot_valid [ENTRIES];
        logic [AGE_BITS-1:0] slot_age   [ENTRIES];
        logic [KEY_W-1:0]    slot_key   [ENTRIES];
        logic                saved_valid;
        logic [AGE_BITS-1:0] saved_age;
        logic [KEY_W-1:0]    saved_key;
        int                  fill_slot;
        logic                fill_open;
        logic [SIZE_W-1:0]   size_limit;
        dir_resp_t           expected_q [$];
        int                  error_count;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_age[i]   = '0;
                slot_key[i]   = '0;
            end
            saved_valid = 1'b0;
            saved_age   = '0;
            saved_key   = '0;
            fill_slot   = 0;
            fill_open   = 1'b0;
            size_limit  = LIMIT_RESET;
            error_count = 0;
        endfunction

        function void set_limit(input logic [SIZE_W-1:0] value);
            size_limit = value;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Every slot other than the one acted on gets one step older.
        // Invalid slots age as well, and the age sticks at the top value.
        function void age_all_but(input int keep);
            for (int i = 0; i < ENTRIES; i++)
                if (i != keep && slot_age[i] != AGE_MAX)
                    slot_age[i] = slot_age[i] + 1'b1;
        endfunction

        function void younger_all_but(input int keep);
            for (int i = 0; i < ENTRIES; i++)
                if (i != keep && slot_age[i] != '0)
                    slot_age[i] = slot_age[i] - 1'b1;
        endfunction

        // The first invalid slot is taken if there is one. Otherwise the first slot
        // with the strictly largest age is taken, and slot 0 when every age is zero.
        function int choose_victim();
            int                  best;
            logic [AGE_BITS-1:0] top;
            best = 0;
            top  = '0;
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (!slot_valid[i])
                    best = i;
            for (int i = 0; i < ENTRIES; i++)
                if (!slot_valid[i])
                    return best;
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_age[i] > top) begin
                    top  = slot_age[i];
                    best = i;
                end
            end
            return best;
        endfunction

        function void note_request(input logic kind, input logic [KEY_W-1:0] key,
                                   input logic [SIZE_W-1:0] size);
            dir_resp_t r;
            int        found;
            int        victim;
            r       = '0;
            r.acted = 1'b1;
            if (kind == KIND_LOOKUP) begin
                found = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (found < 0 && slot_valid[i] && slot_key[i] == key)
                        found = i;
                if (found >= 0) begin
                    slot_age[found] = '0;
                    age_all_but(found);
                    r.hit  = 1'b1;
                    r.slot = SLOT_W'(found);
                end else begin
                    victim = choose_victim();
                    age_all_but(victim);
                    saved_valid        = slot_valid[victim];
                    saved_age          = slot_age[victim];
                    saved_key          = slot_key[victim];
                    slot_valid[victim] = 1'b1;
                    slot_age[victim]   = '0;
                    slot_key[victim]   = key;
                    fill_slot          = victim;
                    fill_open          = 1'b1;
                    r.slot             = SLOT_W'(victim);
                end
            end else if (fill_open) begin
                if (size >= size_limit) begin
                    slot_valid[fill_slot] = saved_valid;
                    slot_age[fill_slot]   = saved_age;
                    slot_key[fill_slot]   = saved_key;
                    younger_all_but(fill_slot);
                    r.rolled_back = 1'b1;
                end
                fill_open = 1'b0;
                r.slot    = SLOT_W'(fill_slot);
            end else begin
                r.acted = 1'b0;
            end
            expected_q.push_back(r);
        endfunction

        task report(input string msg);
            $display("[tb] %0t ns: %s", $time, msg);
            error_count++;
        endtask

        task check_response(input dir_resp_t got);
            dir_resp_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected response hit=%0b slot=%0d rolled_back=%0b acted=%0b",
                                 got.hit, got.slot, got.rolled_back, got.acted));
            end else begin
                want = expected_q.pop_front();
                if (got.hit !== want.hit)
                    report($sformatf("hit is %0b, expected %0b", got.hit, want.hit));
                if (got.slot !== want.slot)
                    report($sformatf("slot is %0d, expected %0d", got.slot, want.slot));
                if (got.rolled_back !== want.rolled_back)
                    report($sformatf("rolled_back is %0b, expected %0b",
                                     got.rolled_back, want.rolled_back));
                if (got.acted !== want.acted)
                    report($sformatf("acted is %0b, expected %0b", got.acted, want.acted));
            end
        endtask

        task check_leftovers();
            if (expected_q.size() != 0)
                report($sformatf("%0d responses never arrived", expected_q.size()));
        endtask
    endclass

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [SIZE_W-1:0]   cfg_wr_data  = '0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic                s_kind       = KIND_LOOKUP;
    logic [KEY_W-1:0]    s_lookup_key = '0;
    logic [SIZE_W-1:0]   s_fill_size  = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic                m_hit;
    logic [SLOT_W-1:0]   m_slot;
    logic                m_rolled_back;
    logic                m_acted;

    dir_scoreboard       sb;
    int                  cycle_count  = 0;
    // While this is set, neither side inserts gaps, so requests go back to back.
    logic                steady       = 1'b0;
    logic [KEY_W-1:0]    key_pool [POOL_KEYS];

    aging_lru_cache_directory DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_lookup_key  (s_lookup_key),
        .s_fill_size   (s_fill_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_slot        (m_slot),
        .m_rolled_back (m_rolled_back),
        .m_acted       (m_acted)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Without a hard limit, a hung handshake would leave the run waiting forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("aging_lru_cache_directory: mismatch");
            $finish;
        end
    end

    // Most gaps are zero or short. About one in thirty is long enough
    // to cover a whole lookup.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    // Completion sizes cluster around the limit, so that both sides of the
    // rollback compare come up often. The extremes of the size field come up too.
    function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] lim);
        case ($urandom_range(0, 5))
            0:       return (lim == '0) ? '0 : lim - 1'b1;
            1:       return lim;
            2:       return (lim == '1) ? lim : lim + 1'b1;
            3:       return SIZE_W'($urandom);
            4:       return '0;
            default: return '1;
        endcase
    endfunction

    // Receiver side. Outputs are read at the clock edge, before any nonblocking
    // update of that edge lands, so m_valid and m_ready hold their pre-edge values.
    // m_ready then gets its value for the next cycle.
    initial begin : response_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_response({m_hit, m_slot, m_rolled_back, m_acted});
            if (stall_left > 0)
                stall_left--;
            else if (!steady && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
            m_ready <= (stall_left == 0);
        end
    end

    // Sends one request and returns at the edge where it is taken. Valid stays high
    // when there is no gap, so the next request can follow with no idle cycle.
    task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                                input logic [SIZE_W-1:0] size);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_lookup_key <= key;
        s_fill_size  <= size;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_request(kind, key, size);
    endtask

    // The sender holds back until every expected response has come. Then it waits
    // long enough for the controller to be idle again.
    task automatic wait_until_quiet();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [SIZE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(value);
    endtask

    // Directed part, run with the reset value of the limit.
    task automatic run_directed();
        logic [KEY_W-1:0] spare_key;
        // A completion with no fill pending must leave the directory as it is.
        send_request(KIND_FILL, '1, '0);
        // Miss into an empty directory, then a hit on the same key while its fill
        // is still pending, then a completion just under the limit.
        send_request(KIND_LOOKUP, '0, '1);
        send_request(KIND_LOOKUP, '0, '0);
        send_request(KIND_FILL, '0, LIMIT_RESET - 1'b1);
        // A completion exactly at the limit rolls the slot back to invalid.
        send_request(KIND_LOOKUP, '1, '0);
        send_request(KIND_FILL, '1, LIMIT_RESET);
        send_request(KIND_FILL, '0, '1);
        // A second miss replaces the pending fill, so the rollback undoes only
        // the newer one. The first fill keeps its slot.
        send_request(KIND_LOOKUP, {KEY_W/2{2'b10}}, '1);
        send_request(KIND_LOOKUP, {KEY_W/2{2'b01}}, '0);
        send_request(KIND_FILL, '0, '1);
        // Fill the remaining slots, so the next miss has to evict the oldest entry.
        for (int i = 0; i < ENTRIES - 2; i++) begin
            send_request(KIND_LOOKUP, {$urandom, $urandom}, SIZE_W'($urandom));
            send_request(KIND_FILL, {$urandom, $urandom}, '0);
        end
        // Eviction undone by a large completion. The evicted key must then hit again.
        spare_key = {$urandom, $urandom};
        send_request(KIND_LOOKUP, spare_key, '0);
        send_request(KIND_FILL, '0, LIMIT_RESET + 1'b1);
        send_request(KIND_LOOKUP, '0, '0);
        // Eviction that stays, followed by a completion with nothing pending.
        send_request(KIND_LOOKUP, ~spare_key, '0);
        send_request(KIND_FILL, '0, '0);
        send_request(KIND_FILL, '0, '1);
    endtask

    initial begin : stimulus
        logic [SIZE_W-1:0] phase_limit;
        int                r;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        wait_until_quiet();

        // Each phase runs under its own size limit: the reset value, the smallest
        // nonzero value, the largest, zero (where every completion with a fill pending
        // rolls back), a random nonzero value, and the reset value again.
        phase_limit = LIMIT_RESET;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph > 0) begin
                case (ph)
                    1:       phase_limit = SIZE_W'(1);
                    2:       phase_limit = '1;
                    3:       phase_limit = '0;
                    4:       phase_limit = SIZE_W'($urandom_range(1, 24'hFFFFFF));
                    default: phase_limit = LIMIT_RESET;
                endcase
                write_limit(phase_limit);
            end
            steady = (ph == 2);

            // A pool of a few more keys than there are slots gives a mix of hits,
            // misses into free slots and evictions. The all-zero and all-one keys
            // stay in the pool.
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int k = 2; k < POOL_KEYS; k++)
                key_pool[k] = {$urandom, $urandom};

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through each phase, the sender lets the pipe run dry.
                if (n == PHASE_ITEMS / 2)
                    wait_until_quiet();
                r = $urandom_range(0, 99);
                if (r < 55)
                    send_request(KIND_LOOKUP, key_pool[$urandom_range(0, POOL_KEYS - 1)],
                                 SIZE_W'($urandom));
                else if (r < 62)
                    send_request(KIND_LOOKUP, {$urandom, $urandom}, SIZE_W'($urandom));
                else
                    send_request(KIND_FILL, {$urandom, $urandom}, pick_size(phase_limit));
            end
            wait_until_quiet();
        end

        sb.check_leftovers();
        if (sb.error_count == 0)
            $display("aging_lru_cache_directory: match");
        else
            $display("aging_lru_cache_directory: mismatch");
        $finish;
    end

endmodule
